/* rtl/mdm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdm_pkg: mecanum drive mixer shared definitions
// widths, fixed-point constants and stage payload types
// ----------------------------------------------------------------------------
package mdm_pkg;

  // fixed-point format of commands and powers
  localparam int FRAC_BITS = 14;
  localparam int FIELD_W   = 16;
  localparam int ONE_Q     = 1 << FRAC_BITS;

  // wheel lanes
  localparam int LANES    = 4;
  localparam int LANE_FL  = 0;
  localparam int LANE_FR  = 1;
  localparam int LANE_BL  = 2;
  localparam int LANE_BR  = 3;

  // sum of three commands grows by two bits, its magnitude needs one less
  localparam int SUM_W = FIELD_W + 2;
  localparam int MAG_W = SUM_W - 1;

  // quotient holds 0 .. ONE_Q
  localparam int QW      = FRAC_BITS + 1;
  localparam int N_CELLS = QW;

  // divisor is max(largest magnitude, one)
  localparam int D_W   = (MAG_W > FRAC_BITS + 1) ? MAG_W : FRAC_BITS + 1;
  localparam int R_W   = D_W + 1;
  localparam int RES_W = (FRAC_BITS + 2 > SUM_W) ? FRAC_BITS + 2 : SUM_W;

  // stages in the block: two front stages, the cells, the output register
  localparam int DEPTH = N_CELLS + 3;

  typedef struct packed {
    logic [LANES-1:0][SUM_W-1:0] sum;
  } sum_stage_t;

  typedef struct packed {
    logic [LANES-1:0]            neg;
    logic [LANES-1:0][R_W-1:0]   rem;
    logic [LANES-1:0][QW-1:0]    quo;
    logic [D_W-1:0]              dvs;
  } div_stage_t;

  // apply the sign, clamp to plus or minus one, cut to field width
  function automatic logic [FIELD_W-1:0] to_power(input logic neg, input logic [QW-1:0] q);
    logic signed [RES_W-1:0] v;
    logic signed [RES_W-1:0] lim;
    v   = neg ? -$signed(RES_W'(q)) : $signed(RES_W'(q));
    lim = RES_W'(ONE_Q);
    if (v > lim) begin
      v = lim;
    end else if (v < -lim) begin
      v = -lim;
    end
    return v[FIELD_W-1:0];
  endfunction

endpackage
`default_nettype wire

/* rtl/mdm_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdm interfaces
// command and wheel power channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface mdm_cmd_if import mdm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] forward_cmd;
  logic signed [FIELD_W-1:0] strafe_cmd;
  logic signed [FIELD_W-1:0] turn_cmd;

  modport source (output valid, forward_cmd, strafe_cmd, turn_cmd, input ready);
  modport sink   (input valid, forward_cmd, strafe_cmd, turn_cmd, output ready);
endinterface

interface mdm_pwr_if import mdm_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] front_left_power;
  logic signed [FIELD_W-1:0] front_right_power;
  logic signed [FIELD_W-1:0] back_left_power;
  logic signed [FIELD_W-1:0] back_right_power;

  modport source (output valid, front_left_power, front_right_power,
                  back_left_power, back_right_power, input ready);
  modport sink   (input valid, front_left_power, front_right_power,
                  back_left_power, back_right_power, output ready);
endinterface
`default_nettype wire

/* rtl/mdm_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdm_front: mixing and divisor selection
// stage a forms the four wheel sums, stage b splits sign and magnitude
// and picks the divisor max(largest magnitude, one)
// ----------------------------------------------------------------------------
module mdm_front import mdm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  mdm_cmd_if.sink         cmd,
  output logic            out_valid,
  input  wire logic       out_ready,
  output div_stage_t      out_data
);

  logic       sa_v_r;
  sum_stage_t sa_r;
  sum_stage_t sa_nxt;
  logic       sb_v_r;
  div_stage_t sb_r;
  div_stage_t sb_nxt;
  logic       sa_rdy;
  logic       sb_rdy;

  logic signed [SUM_W-1:0]       fe, se, te;
  logic signed [SUM_W-1:0]       sv [LANES];
  logic [LANES-1:0][MAG_W-1:0]   mag;
  logic [MAG_W-1:0]              m01, m23, mmax;

  assign sb_rdy    = !sb_v_r || out_ready;
  assign sa_rdy    = !sa_v_r || sb_rdy;
  assign cmd.ready = sa_rdy;

  // wheel mixing
  always_comb begin
    fe = SUM_W'(cmd.forward_cmd);
    se = SUM_W'(cmd.strafe_cmd);
    te = SUM_W'(cmd.turn_cmd);
    sa_nxt.sum[LANE_FL] = fe + se - te;
    sa_nxt.sum[LANE_FR] = fe - se + te;
    sa_nxt.sum[LANE_BL] = fe - se - te;
    sa_nxt.sum[LANE_BR] = fe + se + te;
  end

  // sign, magnitude, largest magnitude
  always_comb begin
    sb_nxt = '0;
    for (int i = 0; i < LANES; i++) begin
      sv[i]          = $signed(sa_r.sum[i]);
      sb_nxt.neg[i]  = sv[i][SUM_W-1];
      mag[i]         = sv[i][SUM_W-1] ? MAG_W'(-sv[i]) : MAG_W'(sv[i]);
      sb_nxt.rem[i]  = R_W'(mag[i]);
      sb_nxt.quo[i]  = '0;
    end
    m01  = (mag[0] > mag[1]) ? mag[0] : mag[1];
    m23  = (mag[2] > mag[3]) ? mag[2] : mag[3];
    mmax = (m01 > m23) ? m01 : m23;
    // at or below one the divisor is one, so the quotient is the magnitude
    sb_nxt.dvs = (D_W'(mmax) > D_W'(ONE_Q)) ? D_W'(mmax) : D_W'(ONE_Q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_v_r <= 1'b0;
      sb_v_r <= 1'b0;
    end else begin
      if (sa_rdy) begin
        sa_v_r <= cmd.valid;
      end
      if (sb_rdy) begin
        sb_v_r <= sa_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sa_rdy && cmd.valid) begin
      sa_r <= sa_nxt;
    end
    if (sb_rdy && sa_v_r) begin
      sb_r <= sb_nxt;
    end
  end

  assign out_valid = sb_v_r;
  assign out_data  = sb_r;

endmodule
`default_nettype wire

/* rtl/mdm_div_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdm_div_cell: one restoring division step
// resolves one quotient bit for all four lanes and hands the shifted
// partial remainder to the next cell
// ----------------------------------------------------------------------------
module mdm_div_cell import mdm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire div_stage_t  in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output div_stage_t       out_data
);

  logic       v_r;
  div_stage_t d_r;
  div_stage_t d_nxt;
  logic [R_W-1:0] diff [LANES];
  logic [R_W-1:0] rsel [LANES];
  logic           qbit [LANES];

  assign in_ready = !v_r || out_ready;

  always_comb begin
    d_nxt = in_data;
    for (int i = 0; i < LANES; i++) begin
      qbit[i]         = in_data.rem[i] >= R_W'(in_data.dvs);
      diff[i]         = in_data.rem[i] - R_W'(in_data.dvs);
      rsel[i]         = qbit[i] ? diff[i] : in_data.rem[i];
      // remainder is below the divisor here, so doubling fits
      d_nxt.rem[i]    = {rsel[i][R_W-2:0], 1'b0};
      d_nxt.quo[i]    = {in_data.quo[i][QW-2:0], qbit[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_data  = d_r;

endmodule
`default_nettype wire

/* rtl/mecanum_drive_mixer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mecanum_drive_mixer_unit: mecanum wheel mixing with normalization
// forward/strafe/turn commands in, four normalized wheel powers out
// ----------------------------------------------------------------------------
// Takes one command request per cycle when the output side does not stall
// and returns one wheel power request per command, in order (Q1.14 at the
// default FRAC_BITS). Two front stages mix the commands and pick the divisor,
// then a row of FRAC_BITS + 1 division cells each resolves one quotient bit
// for all four wheels, and an output register applies the sign and the plus
// or minus one clamp. The row of cells sets the latency; every stage has its
// own valid bit, so bubbles are squeezed out and new commands keep entering
// while a finished result waits, until every stage is full. Throughput is
// one request per cycle when the output side does not stall. The block holds
// no state between requests and needs no clearing after reset.
// ----------------------------------------------------------------------------
module mecanum_drive_mixer_unit import mdm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  mdm_cmd_if.sink   in_cmd,
  mdm_pwr_if.source out_pwr
);

  // chain links: index 0 is the front end output, N_CELLS the last cell
  logic       lnk_v   [N_CELLS+1];
  logic       lnk_rdy [N_CELLS+1];
  div_stage_t lnk_d   [N_CELLS+1];

  // output register
  logic                    ov_r;
  logic [LANES-1:0][FIELD_W-1:0] pw_r;
  logic [LANES-1:0][FIELD_W-1:0] pw_nxt;
  logic                    o_rdy;

  // mixing, magnitude and divisor selection
  mdm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (in_cmd),
    .out_valid (lnk_v[0]),
    .out_ready (lnk_rdy[0]),
    .out_data  (lnk_d[0])
  );

  // one quotient bit per cell, most significant first
  for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
    mdm_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (lnk_v[k]),
      .in_ready  (lnk_rdy[k]),
      .in_data   (lnk_d[k]),
      .out_valid (lnk_v[k+1]),
      .out_ready (lnk_rdy[k+1]),
      .out_data  (lnk_d[k+1])
    );
  end

  // output stage takes a new result when empty or being drained
  assign o_rdy            = !ov_r || out_pwr.ready;
  assign lnk_rdy[N_CELLS] = o_rdy;

  // sign the quotient back, clamp to plus or minus one
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      pw_nxt[i] = to_power(lnk_d[N_CELLS].neg[i], lnk_d[N_CELLS].quo[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (o_rdy) begin
      ov_r <= lnk_v[N_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (o_rdy && lnk_v[N_CELLS]) begin
      pw_r <= pw_nxt;
    end
  end

  assign out_pwr.valid             = ov_r;
  assign out_pwr.front_left_power  = pw_r[LANE_FL];
  assign out_pwr.front_right_power = pw_r[LANE_FR];
  assign out_pwr.back_left_power   = pw_r[LANE_BL];
  assign out_pwr.back_right_power  = pw_r[LANE_BR];

endmodule
`default_nettype wire

/* rtl/mdm_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mdm_checker: port-level checks for the mecanum drive mixer
// watches the command and power channels only
// ----------------------------------------------------------------------------
module mdm_checker import mdm_pkg::*; (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_valid,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic signed [FIELD_W-1:0] fl,
  input wire logic signed [FIELD_W-1:0] fr,
  input wire logic signed [FIELD_W-1:0] bl,
  input wire logic signed [FIELD_W-1:0] br
);

  localparam int CNT_W = $clog2(DEPTH + 2);

  logic [CNT_W-1:0] inflight_r;
  logic [CNT_W-1:0] inflight_nxt;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    inflight_nxt = inflight_r;
    if (in_acc && !out_acc) begin
      inflight_nxt = inflight_r + CNT_W'(1);
    end else if (out_acc && !in_acc) begin
      inflight_nxt = inflight_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  // a stalled result request stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  // no result without a command still in flight
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != '0)
    else $error("result request with no command in flight");

  // the pipeline never holds more than its depth
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= CNT_W'(DEPTH))
    else $error("more commands in flight than pipeline stages");

  // powers stay within plus or minus one
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (fl >= -ONE_Q && fl <= ONE_Q && fr >= -ONE_Q && fr <= ONE_Q &&
                   bl >= -ONE_Q && bl <= ONE_Q && br >= -ONE_Q && br <= ONE_Q))
    else $error("wheel power outside plus or minus one");

  // reset empties the output
  a_reset: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("result request offered right after reset");

endmodule

bind mecanum_drive_mixer_unit mdm_checker u_mdm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_cmd.valid),
  .in_ready  (in_cmd.ready),
  .out_valid (out_pwr.valid),
  .out_ready (out_pwr.ready),
  .fl        (out_pwr.front_left_power),
  .fr        (out_pwr.front_right_power),
  .bl        (out_pwr.back_left_power),
  .br        (out_pwr.back_right_power)
);
`default_nettype wire
